>>> rtl/text_line_scroller_with_char_queue_top_defines.svh
// assertion helpers for the top-level rtl
`ifndef TEXT_LINE_SCROLLER_WITH_CHAR_QUEUE_TOP_DEFINES_SVH
`define TEXT_LINE_SCROLLER_WITH_CHAR_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TXSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TXSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/txsc_pkg.sv
`default_nettype none

package txsc_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ROWS_DEF        = 3;
  localparam int MAX_COLUMNS_DEF = 16;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  localparam logic [4:0] COLUMNS_RST    = 5'd13;
  localparam logic [5:0] ADVANCE_RST    = 6'd12;
  localparam logic [5:0] LINE_HEIGHT_RST = 6'd20;
  localparam logic [7:0] TEXT_TOP_RST   = 8'd19;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_TOP    = 3'd3;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_FLUSH   = 2'd3
  } txsc_cmd_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } txsc_qctl_t;

endpackage

`default_nettype wire

>>> rtl/txsc_queue.sv
`default_nettype none

module txsc_queue import txsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire txsc_qctl_t ctl_i,
  input  wire logic [7:0] push_char_i,
  output logic            empty_o,
  output logic [7:0]      head_char_o
);

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QW-1:0]  LAST_PTR = QW'(QUEUE_DEPTH - 1);
  localparam logic [CTW-1:0] FULL_CNT = CTW'(QUEUE_DEPTH);

  logic [7:0]     ring_mem [QUEUE_DEPTH];
  logic [7:0]     head_char_q;
  logic [QW-1:0]  head_q, tail_q, head_inc, tail_inc;
  logic [CTW-1:0] count_q;
  logic           full;

  assign head_inc    = (head_q == LAST_PTR) ? '0 : head_q + QW'(1);
  assign tail_inc    = (tail_q == LAST_PTR) ? '0 : tail_q + QW'(1);
  assign full        = (count_q == FULL_CNT);
  assign empty_o     = (count_q == '0);
  assign head_char_o = head_char_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      ring_mem[tail_q] <= push_char_i;
    end
    head_char_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (ctl_i.flush) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (ctl_i.push) begin
      tail_q <= tail_inc;
      // a full ring loses its oldest word
      if (full) begin
        head_q <= head_inc;
      end else begin
        count_q <= count_q + CTW'(1);
      end
    end else if (ctl_i.pop) begin
      head_q  <= head_inc;
      count_q <= count_q - CTW'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/text_line_scroller_with_char_queue_top.sv
// Character text console. Commands arrive on the slave stream (tuser: 0 enqueue a
// character, 1 tick, 2 clear all text, 3 flush queue and abort scroll); each drawn
// cell leaves on the master stream with its row, column, pixel position and code,
// tlast marking the final cell of a tick. Enqueue, clear and flush are handled in
// the idle state, and so is a tick that draws nothing; a tick that pops a character
// and starts a scroll passes through the pop state for the queue memory read. A tick
// that prints goes through the print state when a held character is printed, and
// through the pop and print states when one is popped from the queue. A redraw tick
// during a scroll walks every row: the cell memory has one read port with a
// registered output, so each row takes a read state and an emit state. The next
// command is taken while the last cell still sits in the output register; a slow
// consumer stalls the emit and print states. Rows scroll by moving a base pointer, and per-row
// fill counts make unwritten cells read as spaces, so there is no clearing pass
// after reset or clear.
`default_nettype none
`include "text_line_scroller_with_char_queue_top_defines.svh"

module text_line_scroller_with_char_queue_top import txsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ROWS        = ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // char_code
  input  wire logic [1:0]           s_axis_tuser,  // command
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // cell_row[2:0], cell_column[6:3], pixel_x[16:7], pixel_y[26:17], glyph_code[34:27]
  output logic [39:0]               m_axis_tdata,
  output logic                      m_axis_tlast
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NW    = $clog2(MAX_COLUMNS + 1);
  localparam int AW    = RW + CW;
  localparam int CELLS = ROWS * (2 ** CW);
  localparam logic [RW:0]   ROWS_N   = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [7:0]    MAX_COLS8 = 8'(MAX_COLUMNS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EMIT,
    S_POP,
    S_PRINT
  } state_e;

  function automatic logic [RW-1:0] phys_of(input logic [RW-1:0] base,
                                           input logic [RW-1:0] r);
    logic [RW:0] sum;
    sum = {1'b0, base} + {1'b0, r};
    if (sum >= ROWS_N) begin
      sum = sum - ROWS_N;
    end
    return sum[RW-1:0];
  endfunction

  // configuration registers
  logic [4:0] columns_q;
  logic [5:0] advance_q;
  logic [5:0] line_height_q;
  logic [7:0] text_top_q;

  state_e        state_q;
  logic [RW-1:0] base_q, active_q, row_q;
  logic [NW-1:0] cursor_q, redraw_q;
  logic [NW-1:0] fill_q [ROWS];
  logic          scrolling_q, held_valid_q;
  logic [7:0]    held_char_q, print_char_q;
  logic          out_valid_q, out_last_q;
  logic [39:0]   out_data_q;

  logic [7:0]    cells_mem [CELLS];
  logic [7:0]    cell_rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  txsc_qctl_t q_ctl;
  logic       q_empty;
  logic [7:0] q_char;

  txsc_cmd_e     cmd;
  logic          in_accept, out_free, load_out;
  logic [7:0]    cols8;
  logic [NW-1:0] eff_cols, redraw_inc;
  logic          line_full, on_last_row;
  logic [RW-1:0] act_phys, rd_phys, next_base;

  logic [RW-1:0] out_row;
  logic [NW-1:0] out_col;
  logic [7:0]    out_glyph;
  logic          out_last;
  logic [15:0]   px_full, py_full;

  assign cmd       = txsc_cmd_e'(s_axis_tuser);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // column count clamped to 1..MAX_COLUMNS
  always_comb begin
    cols8 = {3'b000, columns_q};
    if (cols8 == 8'd0) begin
      cols8 = 8'd1;
    end
    if (cols8 > MAX_COLS8) begin
      cols8 = MAX_COLS8;
    end
    eff_cols = NW'(cols8);
  end

  assign line_full   = (cursor_q >= eff_cols);
  assign on_last_row = (active_q == LAST_ROW);
  assign redraw_inc  = redraw_q + NW'(1);
  assign act_phys    = phys_of(base_q, active_q);
  assign rd_phys     = phys_of(base_q, row_q);
  assign next_base   = phys_of(base_q, RW'(1));

  assign rd_addr = {rd_phys, redraw_q[CW-1:0]};
  assign wr_addr = {act_phys, cursor_q[CW-1:0]};
  assign wr_en   = (state_q == S_PRINT) && out_free;
  assign load_out = out_free && ((state_q == S_EMIT) || (state_q == S_PRINT));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cells_mem[wr_addr] <= print_char_q;
    end
    cell_rd_q <= cells_mem[rd_addr];
  end

  always_comb begin
    q_ctl.push  = in_accept && (cmd == CMD_ENQUEUE) && (s_axis_tdata != 8'd0);
    q_ctl.flush = in_accept && ((cmd == CMD_CLEAR) || (cmd == CMD_FLUSH));
    q_ctl.pop   = in_accept && (cmd == CMD_TICK) && !scrolling_q && !held_valid_q
                  && !q_empty;
  end

  txsc_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (q_ctl),
    .push_char_i (s_axis_tdata),
    .empty_o     (q_empty),
    .head_char_o (q_char)
  );

  // cell word selection and pixel position
  always_comb begin
    if (state_q == S_EMIT) begin
      out_row   = row_q;
      out_col   = redraw_q;
      // cells past the fill count of their row are blank
      out_glyph = (redraw_q < fill_q[rd_phys]) ? cell_rd_q : SPACE_CODE;
      out_last  = (row_q == LAST_ROW);
    end else begin
      out_row   = active_q;
      out_col   = cursor_q;
      out_glyph = print_char_q;
      out_last  = 1'b1;
    end
    px_full = 16'(out_col) * 16'(advance_q);
    py_full = 16'(text_top_q) + 16'(out_row) * 16'(line_height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q     <= COLUMNS_RST;
      advance_q     <= ADVANCE_RST;
      line_height_q <= LINE_HEIGHT_RST;
      text_top_q    <= TEXT_TOP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLUMNS:     columns_q     <= cfg_data_i[4:0];
        REG_ADVANCE:     advance_q     <= cfg_data_i[5:0];
        REG_LINE_HEIGHT: line_height_q <= cfg_data_i[5:0];
        REG_TEXT_TOP:    text_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_q       <= '0;
      active_q     <= '0;
      row_q        <= '0;
      cursor_q     <= '0;
      redraw_q     <= '0;
      scrolling_q  <= 1'b0;
      held_valid_q <= 1'b0;
      held_char_q  <= '0;
      print_char_q <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_data_q   <= '0;
      for (int i = 0; i < ROWS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_last_q  <= out_last;
        out_data_q  <= {5'b00000, out_glyph, py_full[9:0], px_full[9:0], 4'(out_col),
                        3'(out_row)};
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            unique case (cmd)
              CMD_ENQUEUE: ;
              CMD_TICK: begin
                if (scrolling_q) begin
                  if (redraw_q < eff_cols) begin
                    row_q   <= '0;
                    state_q <= S_READ;
                  end else begin
                    scrolling_q <= 1'b0;
                  end
                end else if (held_valid_q) begin
                  if (line_full && on_last_row) begin
                    // scroll again, the character stays held
                    cursor_q          <= '0;
                    base_q            <= next_base;
                    fill_q[base_q]    <= '0;
                    scrolling_q       <= 1'b1;
                    redraw_q          <= '0;
                  end else begin
                    if (line_full) begin
                      cursor_q <= '0;
                      active_q <= active_q + RW'(1);
                    end
                    held_valid_q <= 1'b0;
                    print_char_q <= held_char_q;
                    state_q      <= S_PRINT;
                  end
                end else if (!q_empty) begin
                  state_q <= S_POP;
                end
              end
              CMD_CLEAR: begin
                base_q       <= '0;
                active_q     <= '0;
                cursor_q     <= '0;
                scrolling_q  <= 1'b0;
                redraw_q     <= '0;
                held_valid_q <= 1'b0;
                held_char_q  <= '0;
                for (int i = 0; i < ROWS; i++) begin
                  fill_q[i] <= '0;
                end
              end
              CMD_FLUSH: begin
                scrolling_q  <= 1'b0;
                redraw_q     <= '0;
                held_valid_q <= 1'b0;
                held_char_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          held_char_q <= q_char;
          if (line_full && on_last_row) begin
            cursor_q       <= '0;
            base_q         <= next_base;
            fill_q[base_q] <= '0;
            scrolling_q    <= 1'b1;
            redraw_q       <= '0;
            held_valid_q   <= 1'b1;
            state_q        <= S_IDLE;
          end else begin
            if (line_full) begin
              cursor_q <= '0;
              active_q <= active_q + RW'(1);
            end
            print_char_q <= q_char;
            state_q      <= S_PRINT;
          end
        end
        S_PRINT: begin
          if (out_free) begin
            fill_q[act_phys] <= cursor_q + NW'(1);
            cursor_q         <= cursor_q + NW'(1);
            state_q          <= S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (row_q == LAST_ROW) begin
              redraw_q <= redraw_inc;
              if (redraw_inc >= eff_cols) begin
                scrolling_q <= 1'b0;
              end
              state_q <= S_IDLE;
            end else begin
              row_q   <= row_q + RW'(1);
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TXSC_ASSERT_IMPL(a_fill_tracks_cursor, 1'b1, fill_q[act_phys] == cursor_q, "row fill count lost the cursor")
  `TXSC_ASSERT_IMPL(a_scroll_on_last_row, scrolling_q, active_q == LAST_ROW, "scroll while not on last row")
  `TXSC_ASSERT_IMPL(a_print_has_room, state_q == S_PRINT, cursor_q < eff_cols, "print past line end")
  `TXSC_ASSERT_NEXT(a_clear_homes_cursor, in_accept && (cmd == CMD_CLEAR), (cursor_q == '0) && (active_q == '0) && !scrolling_q, "clear left cursor or scroll")

endmodule

`default_nettype wire

>>> bench/text_line_scroller_with_char_queue_top_tb.sv
`timescale 1ns / 100ps

module text_line_scroller_with_char_queue_top_tb;
  import txsc_pkg::*;

  localparam int QD   = QUEUE_DEPTH_DEF;
  localparam int NROW = ROWS_DEF;
  localparam int NCOL = MAX_COLUMNS_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int FIRST_SPARE_REG = 4;

  typedef struct packed {
    logic [2:0] row;
    logic [3:0] col;
    logic [9:0] px;
    logic [9:0] py;
    logic [7:0] glyph;
    logic       last;
  } cell_draw_t;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_val;
    txsc_cmd_e            cmd;
    logic [7:0]           code;
    bit                   typed;
    cell_draw_t           want;
  } script_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;  // char_code
  logic [1:0]           s_axis_tuser;  // command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // cell_row, cell_column, pixel_x, pixel_y, glyph_code
  logic [39:0]          m_axis_tdata;
  logic                 m_axis_tlast;

  text_line_scroller_with_char_queue_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // console model state
  logic [4:0] cols_reg;
  logic [5:0] adv_reg;
  logic [5:0] lh_reg;
  logic [7:0] top_reg;
  logic [7:0] ring_mem [QD];
  int         ring_rd, ring_wr, ring_fill;
  logic [7:0] screen [NROW][NCOL];
  int         row_p, cur_col, redraw_col;
  bit         scroll_on, held_on;
  logic [7:0] held_ch;

  cell_draw_t  step_draws[$];
  cell_draw_t  draws_due[$];
  script_row_t script_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int words_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int width_in_use();
    int c;
    c = cols_reg;
    if (c < 1) c = 1;
    if (c > NCOL) c = NCOL;
    return c;
  endfunction

  function automatic void add_draw(int r, int c, logic [7:0] g);
    cell_draw_t d;
    d.row   = r[2:0];
    d.col   = c[3:0];
    d.px    = 10'(c * adv_reg);
    d.py    = 10'(top_reg + r * lh_reg);
    d.glyph = g;
    d.last  = 1'b0;
    step_draws.push_back(d);
  endfunction

  function automatic void drop_queue();
    ring_rd    = 0;
    ring_wr    = 0;
    ring_fill  = 0;
    scroll_on  = 1'b0;
    redraw_col = 0;
    held_ch    = 8'd0;
    held_on    = 1'b0;
  endfunction

  function automatic void blank_screen();
    foreach (screen[r, c]) screen[r][c] = SPACE_CODE;
    row_p   = 0;
    cur_col = 0;
  endfunction

  function automatic void reset_console();
    cols_reg = COLUMNS_RST;
    adv_reg  = ADVANCE_RST;
    lh_reg   = LINE_HEIGHT_RST;
    top_reg  = TEXT_TOP_RST;
    foreach (ring_mem[i]) ring_mem[i] = 8'd0;
    blank_screen();
    drop_queue();
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      REG_COLUMNS:     cols_reg = val[4:0];
      REG_ADVANCE:     adv_reg  = val[5:0];
      REG_LINE_HEIGHT: lh_reg   = val[5:0];
      REG_TEXT_TOP:    top_reg  = val;
      default: ;
    endcase
  endfunction

  // wrap to the next row, shifting the screen up when already on the bottom one
  function automatic void next_row();
    cur_col = 0;
    row_p++;
    if (row_p >= NROW) begin
      row_p = NROW - 1;
      for (int c = 0; c < NCOL; c++) begin
        for (int r = 0; r + 1 < NROW; r++) screen[r][c] = screen[r + 1][c];
        screen[NROW - 1][c] = SPACE_CODE;
      end
      scroll_on  = 1'b1;
      redraw_col = 0;
    end
  endfunction

  function automatic void put_glyph(logic [7:0] g);
    screen[row_p][cur_col % NCOL] = g;
    add_draw(row_p, cur_col % NCOL, g);
    cur_col++;
  endfunction

  function automatic void run_tick();
    int         cols;
    logic [7:0] ch;
    cols = width_in_use();
    if (scroll_on) begin
      if (redraw_col < cols) begin
        for (int r = 0; r < NROW; r++) add_draw(r, redraw_col, screen[r][redraw_col % NCOL]);
        redraw_col++;
      end
      if (redraw_col >= cols) scroll_on = 1'b0;
      return;
    end
    if (held_on) begin
      if (cur_col >= cols) begin
        next_row();
        if (scroll_on) return;
      end
      held_on = 1'b0;
      put_glyph(held_ch);
      return;
    end
    if (ring_fill == 0) return;
    ch        = ring_mem[ring_rd];
    ring_rd   = (ring_rd + 1) % QD;
    ring_fill--;
    if (cur_col >= cols) begin
      held_ch = ch;
      held_on = 1'b1;
      next_row();
      if (scroll_on) return;
      held_on = 1'b0;
    end
    put_glyph(ch);
  endfunction

  function automatic void advance_console(txsc_cmd_e cmd, logic [7:0] code);
    step_draws.delete();
    case (cmd)
      CMD_ENQUEUE: begin
        if (code != 8'd0) begin
          // full ring drops its oldest character
          if (ring_fill >= QD) begin
            ring_rd = (ring_rd + 1) % QD;
            ring_fill--;
          end
          ring_mem[ring_wr] = code;
          ring_wr = (ring_wr + 1) % QD;
          ring_fill++;
        end
      end
      CMD_TICK: run_tick();
      CMD_CLEAR: begin
        blank_screen();
        drop_queue();
      end
      default: drop_queue();
    endcase
    if (step_draws.size() != 0) step_draws[step_draws.size() - 1].last = 1'b1;
  endfunction

  function automatic script_row_t cmd_row(txsc_cmd_e cmd, logic [7:0] code);
    script_row_t s;
    s.is_reg  = 1'b0;
    s.reg_idx = REG_COLUMNS;
    s.reg_val = 8'd0;
    s.cmd     = cmd;
    s.code    = code;
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic script_row_t draw_row(txsc_cmd_e cmd, logic [7:0] code, int r, int c,
                                           int x, int y, int g);
    script_row_t s;
    s       = cmd_row(cmd, code);
    s.typed = 1'b1;
    s.want  = '{row: r[2:0], col: c[3:0], px: x[9:0], py: y[9:0], glyph: g[7:0], last: 1'b1};
    return s;
  endfunction

  function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    script_row_t s;
    s         = cmd_row(CMD_ENQUEUE, 8'd0);
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  task automatic put_word(input txsc_cmd_e cmd, input logic [7:0] code, input bit typed,
                          input cell_draw_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_console(cmd, code);
    if (typed) draws_due.push_back(want);
    else foreach (step_draws[i]) draws_due.push_back(step_draws[i]);
    if (!(cmd == CMD_ENQUEUE && code == 8'd0)) words_taken++;
  endtask

  task automatic send(input txsc_cmd_e cmd, input logic [7:0] code);
    put_word(cmd, code, 1'b0, '0);
  endtask

  // leaves valid high; the caller lowers it after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (draws_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic shuffle_settings();
    logic [7:0] width;
    if ($urandom_range(3) == 0) width = 8'($urandom_range(0, 255));
    else width = 8'($urandom_range(1, 6));
    write_reg(REG_COLUMNS, width);
    write_reg(REG_ADVANCE, 8'($urandom_range(0, 255)));
    write_reg(REG_LINE_HEIGHT, 8'($urandom_range(0, 255)));
    write_reg(REG_TEXT_TOP, 8'($urandom_range(0, 255)));
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, 7)), 8'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
  endtask

  // bursts of characters followed by ticks, with enqueues, flushes and clears mixed in
  task automatic random_phase(input int quota);
    int start, burst, ticks, pick;
    start = words_taken;
    while (words_taken - start < quota) begin
      if ($urandom_range(2) == 0) begin
        wait_drained();
        shuffle_settings();
      end else if ($urandom_range(5) == 0) begin
        wait_drained();
      end
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(15) == 0) send(CMD_ENQUEUE, 8'd0);
        send(CMD_ENQUEUE, 8'($urandom_range(1, 255)));
      end
      ticks = $urandom_range(burst / 2, burst + 18);
      for (int k = 0; k < ticks; k++) begin
        pick = $urandom_range(29);
        if (pick == 0) send(CMD_FLUSH, 8'($urandom_range(0, 255)));
        else if (pick == 1) send(CMD_CLEAR, 8'($urandom_range(0, 255)));
        else if (pick < 5) send(CMD_ENQUEUE, 8'($urandom_range(0, 255)));
        else send(CMD_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (draws_due.size() == 0) begin
        $error("draw with nothing pending: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        check_field("cell_row",    draws_due[0].row,   m_axis_tdata[2:0]);
        check_field("cell_column", draws_due[0].col,   m_axis_tdata[6:3]);
        check_field("pixel_x",     draws_due[0].px,    m_axis_tdata[16:7]);
        check_field("pixel_y",     draws_due[0].py,    m_axis_tdata[26:17]);
        check_field("glyph_code",  draws_due[0].glyph, m_axis_tdata[34:27]);
        check_field("last_of_run", draws_due[0].last,  m_axis_tlast);
        void'(draws_due.pop_front());
      end
    end
  end

  initial begin
    script_row_t row;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_COLUMNS;
    cfg_data_i    = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = CMD_ENQUEUE;
    m_axis_tready = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 71;
    fail_count    = 0;
    words_taken   = 0;
    reset_console();

    // empty ring, ignored zero, first prints
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd0));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd65));
    script_rows.push_back(draw_row(CMD_TICK, 8'd0, 0, 0, 0, 19, 65));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd255));
    script_rows.push_back(draw_row(CMD_TICK, 8'd255, 0, 1, 12, 19, 255));
    // zero columns acts as one: every character wraps, third one scrolls
    script_rows.push_back(reg_row(REG_COLUMNS, 8'd0));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd1));
    script_rows.push_back(draw_row(CMD_TICK, 8'd0, 1, 0, 0, 39, 1));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd128));
    script_rows.push_back(draw_row(CMD_TICK, 8'd0, 2, 0, 0, 59, 128));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd127));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    // pixel extremes and an ignored register index
    script_rows.push_back(reg_row(REG_ADVANCE, 8'd63));
    script_rows.push_back(reg_row(REG_LINE_HEIGHT, 8'd63));
    script_rows.push_back(reg_row(REG_TEXT_TOP, 8'd255));
    script_rows.push_back(reg_row(REG_COLUMNS, 8'd2));
    script_rows.push_back(reg_row(REG_SPARE, 8'hAA));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd66));
    script_rows.push_back(draw_row(CMD_TICK, 8'd0, 2, 1, 63, 381, 66));
    // shrink the width in mid scroll so the redraw stops early
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd67));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(reg_row(REG_COLUMNS, 8'd1));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd5));
    script_rows.push_back(cmd_row(CMD_FLUSH, 8'd0));
    script_rows.push_back(cmd_row(CMD_TICK, 8'd0));
    // width above the maximum, then clear back to the top left
    script_rows.push_back(reg_row(REG_COLUMNS, 8'd31));
    script_rows.push_back(cmd_row(CMD_CLEAR, 8'd0));
    script_rows.push_back(cmd_row(CMD_ENQUEUE, 8'd200));
    script_rows.push_back(draw_row(CMD_TICK, 8'd0, 0, 0, 0, 255, 200));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_rows[i]) begin
      row = script_rows[i];
      if (row.is_reg) begin
        if (i == 0 || !script_rows[i - 1].is_reg) wait_drained();
        write_reg(row.reg_idx, row.reg_val);
        if (i + 1 == script_rows.size() || !script_rows[i + 1].is_reg) cfg_valid_i <= 1'b0;
      end else begin
        put_word(row.cmd, row.code, row.typed, row.want);
      end
    end

    wait_drained();
    write_reg(REG_COLUMNS, 8'd3);
    write_reg(REG_ADVANCE, 8'd0);
    write_reg(REG_LINE_HEIGHT, 8'd0);
    write_reg(REG_TEXT_TOP, 8'd0);
    cfg_valid_i <= 1'b0;
    random_phase(95);

    wait_drained();
    send_idle_pct = 71;
    recv_idle_pct = 23;
    write_reg(REG_COLUMNS, 8'd16);
    write_reg(REG_ADVANCE, 8'd255);
    write_reg(REG_LINE_HEIGHT, 8'd63);
    write_reg(REG_TEXT_TOP, 8'd255);
    cfg_valid_i <= 1'b0;
    random_phase(95);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shuffle_settings();
    random_phase(95);

    wait_drained();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
